// File: rtl/core/dqp_pkg.sv
// Package for the DNS query parser: payload structs, phase and verdict codes,
// and the character cleanup function. No dependencies.
`timescale 1ns / 1ps
package dqp_pkg;

  localparam int unsigned LabelGuardDefault   = 130;
  localparam int unsigned MaxNameBytesDefault = 255;
  localparam int unsigned MinUdpSizeDefault   = 512;

  localparam logic [15:0] OptType  = 16'd41;
  localparam int unsigned OutDepth = 4;

  localparam logic [3:0] PhHeader = 4'd0;
  localparam logic [3:0] PhQlen   = 4'd1;
  localparam logic [3:0] PhQlabel = 4'd2;
  localparam logic [3:0] PhQfixed = 4'd3;
  localparam logic [3:0] PhRname  = 4'd4;
  localparam logic [3:0] PhRlabel = 4'd5;
  localparam logic [3:0] PhRptr   = 4'd6;
  localparam logic [3:0] PhRfixed = 4'd7;
  localparam logic [3:0] PhRdata  = 4'd8;
  localparam logic [3:0] PhDone   = 4'd9;
  localparam logic [3:0] PhHalt   = 4'd10;

  localparam logic [1:0] VerdictOk     = 2'd0;
  localparam logic [1:0] VerdictDrop   = 2'd1;
  localparam logic [1:0] VerdictFormErr = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  name_char;
    logic        run_last;
    logic [1:0]  verdict;
    logic [15:0] query_id;
    logic [15:0] query_flags;
    logic [15:0] question_type;
    logic [15:0] question_class;
    logic [15:0] question_end;
    logic        edns_present;
    logic [15:0] payload_size;
    logic        dnssec_ok;
    logic [7:0]  name_valid_length;
  } out_t;

  // Upper case folds to lower case; anything outside [a-z0-9-_] becomes '_'.
  function automatic logic [7:0] clean_char(input logic [7:0] c);
    logic [7:0] r;
    r = 8'h5F;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
             c == 8'h2D || c == 8'h5F) r = c;
    return r;
  endfunction

endpackage

// File: rtl/core/dns_query_parser.sv
// DNS query parser top level: byte-wise header, question and record walk.
// Depends on dqp_pkg.
//
//   channel | signals                         | payload
//   in      | in_valid_i / in_ready_o         | dqp_pkg::in_t  (one message byte)
//   out     | out_valid_o / out_ready_i       | dqp_pkg::out_t (name char or verdict)
//
// One byte is taken per cycle while input ready is high; each byte is decoded in the cycle it is accepted
// and its zero, one or two results go into a four-entry output queue.
// Results are registered in the queue before they appear on the output.
// Input ready drops only while fewer than two queue entries are free.
// Reset (asynchronous, active low) puts the parser in the header phase
// with an empty queue.
`timescale 1ns / 1ps
module dns_query_parser #(
  parameter int unsigned LABEL_GUARD    = dqp_pkg::LabelGuardDefault,
  parameter int unsigned MAX_NAME_BYTES = dqp_pkg::MaxNameBytesDefault,
  parameter int unsigned MIN_UDP_SIZE   = dqp_pkg::MinUdpSizeDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dqp_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dqp_pkg::out_t  out_data_o
);

  localparam logic [7:0]  LabelGuardC = 8'(LABEL_GUARD);
  localparam logic [8:0]  MaxNameC    = 9'(MAX_NAME_BYTES);
  localparam logic [15:0] MinUdpC     = 16'(MIN_UDP_SIZE);

  logic [3:0]  phase_q, phase_d;
  logic [15:0] bpos_q, bpos_d;
  logic [15:0] hid_q, hid_d, hflags_q, hflags_d;
  logic [15:0] qdcount_q, qdcount_d, ancount_q, ancount_d;
  logic [15:0] nscount_q, nscount_d, arcount_q, arcount_d;
  logic [16:0] rec_idx_q, rec_idx_d;
  logic [5:0]  lab_rem_q, lab_rem_d;
  logic [7:0]  name_tot_q, name_tot_d;
  logic [7:0]  guard_q, guard_d;
  logic        started_q, started_d;
  logic [15:0] rtype_q, rtype_d, rclass_q, rclass_d;
  logic [31:0] rttl_q, rttl_d;
  logic [15:0] rdlen_q, rdlen_d;
  logic [15:0] qtype_q, qtype_d, qclass_q, qclass_d, qend_q, qend_d;
  logic [1:0]  early_q, early_d;
  logic        wfail_q, wfail_d;
  logic        opt_seen_q, opt_seen_d, opt_do_q, opt_do_d;
  logic [15:0] opt_size_q, opt_size_d;

  logic        in_fire, out_fire, finish;
  logic [7:0]  b;
  logic [17:0] rec_total;
  logic [8:0]  name_sum;
  logic [3:0]  k;
  logic [1:0]  verd;
  logic [16:0] rec_next;
  dqp_pkg::out_t res0, res1;
  logic [1:0]  n_res;

  dqp_pkg::out_t fifo_q [dqp_pkg::OutDepth];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign b         = in_data_i.data_byte;
  assign rec_total = 18'(ancount_q) + 18'(nscount_q) + 18'(arcount_q);
  assign name_sum  = 9'(name_tot_q) + 9'(b) + 9'd1;
  assign k         = 4'd10 - lab_rem_q[3:0];
  assign rec_next  = rec_idx_q + 17'd1;

  always_comb begin
    phase_d = phase_q;   bpos_d = bpos_q;     hid_d = hid_q;     hflags_d = hflags_q;
    qdcount_d = qdcount_q; ancount_d = ancount_q; nscount_d = nscount_q;
    arcount_d = arcount_q; rec_idx_d = rec_idx_q; lab_rem_d = lab_rem_q;
    name_tot_d = name_tot_q; guard_d = guard_q; started_d = started_q;
    rtype_d = rtype_q;   rclass_d = rclass_q; rttl_d = rttl_q;   rdlen_d = rdlen_q;
    qtype_d = qtype_q;   qclass_d = qclass_q; qend_d = qend_q;   early_d = early_q;
    wfail_d = wfail_q;   opt_seen_d = opt_seen_q; opt_do_d = opt_do_q;
    opt_size_d = opt_size_q;
    finish = 1'b0;
    verd   = dqp_pkg::VerdictOk;
    res0   = '0;
    res1   = '0;
    n_res  = 2'd0;
    if (in_fire) begin
      unique case (phase_q)
        dqp_pkg::PhHeader: begin
          if (bpos_q[15:1] == 15'd0) begin
            if (!bpos_q[0]) hid_d[15:8] = b; else hid_d[7:0] = b;
          end else if (bpos_q[15:1] == 15'd1) begin
            if (!bpos_q[0]) hflags_d[15:8] = b; else hflags_d[7:0] = b;
          end else if (bpos_q[15:1] == 15'd2) begin
            if (!bpos_q[0]) qdcount_d[15:8] = b; else qdcount_d[7:0] = b;
          end else if (bpos_q[15:1] == 15'd3) begin
            if (!bpos_q[0]) ancount_d[15:8] = b; else ancount_d[7:0] = b;
          end else if (bpos_q[15:1] == 15'd4) begin
            if (!bpos_q[0]) nscount_d[15:8] = b; else nscount_d[7:0] = b;
          end else begin
            if (!bpos_q[0]) arcount_d[15:8] = b; else arcount_d[7:0] = b;
          end
          if (bpos_q == 16'd2 && b[7]) early_d = dqp_pkg::VerdictDrop;
          if (bpos_q == 16'd5 && qdcount_d != 16'd1 && early_d == dqp_pkg::VerdictOk)
            early_d = dqp_pkg::VerdictFormErr;
          if (bpos_q >= 16'd11)
            phase_d = (early_d == dqp_pkg::VerdictOk) ? dqp_pkg::PhQlen : dqp_pkg::PhHalt;
        end
        dqp_pkg::PhQlen: begin
          if (b == 8'd0) begin
            lab_rem_d = 6'd4;
            phase_d   = dqp_pkg::PhQfixed;
          end else if (b[7:6] != 2'b00 || name_sum > MaxNameC) begin
            early_d = dqp_pkg::VerdictFormErr;
            phase_d = dqp_pkg::PhHalt;
          end else begin
            name_tot_d = name_sum[7:0];
            if (started_q) begin
              res0.name_char         = 8'h2E;
              res0.name_valid_length = name_sum[7:0];
              n_res = 2'd1;
            end
            started_d = 1'b1;
            lab_rem_d = b[5:0];
            phase_d   = dqp_pkg::PhQlabel;
          end
        end
        dqp_pkg::PhQlabel: begin
          res0.name_char         = dqp_pkg::clean_char(b);
          res0.name_valid_length = name_tot_q;
          n_res     = 2'd1;
          lab_rem_d = lab_rem_q - 6'd1;
          if (lab_rem_d == 6'd0) phase_d = dqp_pkg::PhQlen;
        end
        dqp_pkg::PhQfixed: begin
          if (lab_rem_q >= 6'd3) qtype_d = {qtype_q[7:0], b};
          else qclass_d = {qclass_q[7:0], b};
          lab_rem_d = lab_rem_q - 6'd1;
          if (lab_rem_d == 6'd0) begin
            qend_d    = bpos_q + 16'd1;
            rec_idx_d = '0;
            if (rec_total == 18'd0) phase_d = dqp_pkg::PhDone;
            else begin
              guard_d = '0;
              phase_d = dqp_pkg::PhRname;
            end
          end
        end
        dqp_pkg::PhRname: begin
          if (guard_q >= LabelGuardC) begin
            wfail_d = 1'b1;
            phase_d = dqp_pkg::PhHalt;
          end else if (b == 8'd0) begin
            lab_rem_d = 6'd10;
            phase_d   = dqp_pkg::PhRfixed;
          end else if (b[7:6] == 2'b11) begin
            phase_d = dqp_pkg::PhRptr;
          end else if (b[7:6] != 2'b00) begin
            wfail_d = 1'b1;
            phase_d = dqp_pkg::PhHalt;
          end else begin
            guard_d   = guard_q + 8'd1;
            lab_rem_d = b[5:0];
            phase_d   = dqp_pkg::PhRlabel;
          end
        end
        dqp_pkg::PhRlabel: begin
          lab_rem_d = lab_rem_q - 6'd1;
          if (lab_rem_d == 6'd0) phase_d = dqp_pkg::PhRname;
        end
        dqp_pkg::PhRptr: begin
          lab_rem_d = 6'd10;
          phase_d   = dqp_pkg::PhRfixed;
        end
        dqp_pkg::PhRfixed: begin
          if (k < 4'd2) rtype_d = {rtype_q[7:0], b};
          else if (k < 4'd4) rclass_d = {rclass_q[7:0], b};
          else if (k < 4'd8) rttl_d = {rttl_q[23:0], b};
          else rdlen_d = {rdlen_q[7:0], b};
          lab_rem_d = lab_rem_q - 6'd1;
          if (lab_rem_d == 6'd0) begin
            if (rdlen_d == 16'd0) finish = 1'b1;
            else phase_d = dqp_pkg::PhRdata;
          end
        end
        dqp_pkg::PhRdata: begin
          rdlen_d = rdlen_q - 16'd1;
          if (rdlen_d == 16'd0) finish = 1'b1;
        end
        default: ;
      endcase

      if (finish) begin
        if (rtype_q == dqp_pkg::OptType &&
            18'(rec_idx_q) >= 18'(ancount_q) + 18'(nscount_q)) begin
          opt_seen_d = 1'b1;
          opt_size_d = (rclass_q < MinUdpC) ? MinUdpC : rclass_q;
          opt_do_d   = rttl_q[15];
        end
        rec_idx_d = rec_next;
        if (18'(rec_next) >= rec_total) phase_d = dqp_pkg::PhDone;
        else begin
          guard_d = '0;
          phase_d = dqp_pkg::PhRname;
        end
      end

      if (bpos_q != 16'hFFFF) bpos_d = bpos_q + 16'd1;

      if (in_data_i.final_byte) begin
        if (bpos_q < 16'd11) verd = dqp_pkg::VerdictDrop;
        else if (early_d != dqp_pkg::VerdictOk) verd = early_d;
        else if (phase_d <= dqp_pkg::PhQfixed) verd = dqp_pkg::VerdictFormErr;
        else verd = dqp_pkg::VerdictOk;
        res1 = '0;
        res1.run_last          = 1'b1;
        res1.verdict           = verd;
        res1.query_id          = hid_d;
        res1.query_flags       = hflags_d;
        res1.name_valid_length = name_tot_d;
        if (verd == dqp_pkg::VerdictOk) begin
          res1.question_type  = qtype_d;
          res1.question_class = qclass_d;
          res1.question_end   = qend_d;
          if (phase_d == dqp_pkg::PhDone && !wfail_d && opt_seen_d) begin
            res1.edns_present = 1'b1;
            res1.payload_size = opt_size_d;
            res1.dnssec_ok    = opt_do_d;
          end
        end
        if (n_res == 2'd0) res0 = res1;
        n_res = n_res + 2'd1;
        // The next message starts from a clean state.
        phase_d = dqp_pkg::PhHeader; bpos_d = '0; hid_d = '0; hflags_d = '0;
        qdcount_d = '0; ancount_d = '0; nscount_d = '0; arcount_d = '0;
        rec_idx_d = '0; lab_rem_d = '0; name_tot_d = '0; guard_d = '0;
        started_d = 1'b0; rtype_d = '0; rclass_d = '0; rttl_d = '0; rdlen_d = '0;
        qtype_d = '0; qclass_d = '0; qend_d = '0; early_d = dqp_pkg::VerdictOk;
        wfail_d = 1'b0; opt_seen_d = 1'b0; opt_do_d = 1'b0; opt_size_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dqp_pkg::PhHeader; bpos_q <= '0; hid_q <= '0; hflags_q <= '0;
      qdcount_q <= '0; ancount_q <= '0; nscount_q <= '0; arcount_q <= '0;
      rec_idx_q <= '0; lab_rem_q <= '0; name_tot_q <= '0; guard_q <= '0;
      started_q <= 1'b0; rtype_q <= '0; rclass_q <= '0; rttl_q <= '0; rdlen_q <= '0;
      qtype_q <= '0; qclass_q <= '0; qend_q <= '0; early_q <= dqp_pkg::VerdictOk;
      wfail_q <= 1'b0; opt_seen_q <= 1'b0; opt_do_q <= 1'b0; opt_size_q <= '0;
    end else begin
      phase_q <= phase_d; bpos_q <= bpos_d; hid_q <= hid_d; hflags_q <= hflags_d;
      qdcount_q <= qdcount_d; ancount_q <= ancount_d; nscount_q <= nscount_d;
      arcount_q <= arcount_d; rec_idx_q <= rec_idx_d; lab_rem_q <= lab_rem_d;
      name_tot_q <= name_tot_d; guard_q <= guard_d; started_q <= started_d;
      rtype_q <= rtype_d; rclass_q <= rclass_d; rttl_q <= rttl_d; rdlen_q <= rdlen_d;
      qtype_q <= qtype_d; qclass_q <= qclass_d; qend_q <= qend_d; early_q <= early_d;
      wfail_q <= wfail_d; opt_seen_q <= opt_seen_d; opt_do_q <= opt_do_d;
      opt_size_q <= opt_size_d;
    end
  end

  // Output queue: one byte can produce two results, so input is taken only
  // while at least two entries are free.
  assign in_ready_o  = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) fifo_q[wr_q] <= res0;
    if (n_res == 2'd2) fifo_q[wr_q + 2'd1] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_res;
      if (out_fire) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(n_res) - 3'(out_fire);
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(dqp_pkg::OutDepth))
    else $error("output queue overflow");

  a_last_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.final_byte |=> phase_q == dqp_pkg::PhHeader && bpos_q == 16'd0)
    else $error("parser not back in header phase after final byte");

  a_verdict_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.run_last |-> out_data_o.verdict != 2'd3)
    else $error("undefined verdict code");

  a_name_no_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.run_last |-> out_data_o.verdict == dqp_pkg::VerdictOk &&
    out_data_o.query_id == 16'd0)
    else $error("name result carries verdict fields");

endmodule

// File: test/dqp_checker.sv
// Checker for the DNS query parser: watches both channels, predicts the
// results of every accepted byte and compares them in order. Depends on dqp_pkg.
`timescale 1ns / 1ps
module dqp_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  dqp_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  dqp_pkg::out_t out_data_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);

  dqp_pkg::out_t expected_results[$];

  logic [3:0]  phase;
  int unsigned pos;
  int unsigned hdr[6];
  int unsigned rec_idx, lab_rem, name_len, guard_cnt, started;
  int unsigned rtype, rclass, rttl, rd_rem;
  int unsigned q_type, q_class, q_end;
  logic [1:0]  early;
  logic        walk_bad, opt_hit, opt_dnssec;
  int unsigned opt_udp;

  function automatic logic [7:0] sanitize(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c + 8'd32;
    if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "-" || c == "_") return c;
    return "_";
  endfunction

  task automatic clear_state();
    phase = dqp_pkg::PhHeader;
    pos = 0;
    foreach (hdr[i]) hdr[i] = 0;
    rec_idx = 0; lab_rem = 0; name_len = 0; guard_cnt = 0; started = 0;
    rtype = 0; rclass = 0; rttl = 0; rd_rem = 0;
    q_type = 0; q_class = 0; q_end = 0;
    early = dqp_pkg::VerdictOk;
    walk_bad = 0; opt_hit = 0; opt_dnssec = 0; opt_udp = 0;
  endtask

  task automatic push_char(input logic [7:0] ch);
    dqp_pkg::out_t r;
    r = '0;
    r.name_char = ch;
    r.name_valid_length = name_len > 255 ? 8'hFF : name_len[7:0];
    expected_results = {expected_results, r};
  endtask

  task automatic close_record();
    if (rtype == dqp_pkg::OptType && rec_idx >= hdr[3] + hdr[4]) begin
      opt_hit = 1;
      opt_udp = rclass < dqp_pkg::MinUdpSizeDefault ? dqp_pkg::MinUdpSizeDefault : rclass;
      opt_dnssec = rttl[15];
    end
    rec_idx = (rec_idx + 1) & 32'h1FFFF;
    if (rec_idx >= hdr[3] + hdr[4] + hdr[5]) phase = dqp_pkg::PhDone;
    else begin
      guard_cnt = 0;
      phase = dqp_pkg::PhRname;
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    int unsigned idx, sel, k;
    logic [1:0] v;
    dqp_pkg::out_t r;
    idx = pos;
    case (phase)
      dqp_pkg::PhHeader: begin
        sel = (idx >> 1) > 5 ? 5 : idx >> 1;
        if (!idx[0]) hdr[sel] = (hdr[sel] & 32'hFF) | (b << 8);
        else hdr[sel] = (hdr[sel] & 32'hFF00) | b;
        if (idx == 2 && b[7]) early = dqp_pkg::VerdictDrop;
        if (idx == 5 && hdr[2] != 1 && early == dqp_pkg::VerdictOk)
          early = dqp_pkg::VerdictFormErr;
        if (idx >= 11)
          phase = early == dqp_pkg::VerdictOk ? dqp_pkg::PhQlen : dqp_pkg::PhHalt;
      end
      dqp_pkg::PhQlen: begin
        if (b == 0) begin
          lab_rem = 4;
          phase = dqp_pkg::PhQfixed;
        end else if ((b & 8'hC0) != 0 ||
                     name_len + b + 1 > dqp_pkg::MaxNameBytesDefault) begin
          early = dqp_pkg::VerdictFormErr;
          phase = dqp_pkg::PhHalt;
        end else begin
          name_len += b + 1;
          if (started != 0) push_char(".");
          started = 1;
          lab_rem = b;
          phase = dqp_pkg::PhQlabel;
        end
      end
      dqp_pkg::PhQlabel: begin
        push_char(sanitize(b));
        lab_rem = (lab_rem - 1) & 32'h3F;
        if (lab_rem == 0) phase = dqp_pkg::PhQlen;
      end
      dqp_pkg::PhQfixed: begin
        if (lab_rem >= 3) q_type = ((q_type << 8) | b) & 32'hFFFF;
        else q_class = ((q_class << 8) | b) & 32'hFFFF;
        lab_rem = (lab_rem - 1) & 32'h3F;
        if (lab_rem == 0) begin
          q_end = (idx + 1) & 32'hFFFF;
          rec_idx = 0;
          if (hdr[3] + hdr[4] + hdr[5] == 0) phase = dqp_pkg::PhDone;
          else begin
            guard_cnt = 0;
            phase = dqp_pkg::PhRname;
          end
        end
      end
      dqp_pkg::PhRname: begin
        if (guard_cnt >= dqp_pkg::LabelGuardDefault) begin
          walk_bad = 1;
          phase = dqp_pkg::PhHalt;
        end else if (b == 0) begin
          lab_rem = 10;
          phase = dqp_pkg::PhRfixed;
        end else if ((b & 8'hC0) == 8'hC0) begin
          phase = dqp_pkg::PhRptr;
        end else if ((b & 8'hC0) != 0) begin
          walk_bad = 1;
          phase = dqp_pkg::PhHalt;
        end else begin
          guard_cnt = (guard_cnt + 1) & 32'hFF;
          lab_rem = b;
          phase = dqp_pkg::PhRlabel;
        end
      end
      dqp_pkg::PhRlabel: begin
        lab_rem = (lab_rem - 1) & 32'h3F;
        if (lab_rem == 0) phase = dqp_pkg::PhRname;
      end
      dqp_pkg::PhRptr: begin
        lab_rem = 10;
        phase = dqp_pkg::PhRfixed;
      end
      dqp_pkg::PhRfixed: begin
        k = 10 - lab_rem;
        if (k < 2) rtype = ((rtype << 8) | b) & 32'hFFFF;
        else if (k < 4) rclass = ((rclass << 8) | b) & 32'hFFFF;
        else if (k < 8) rttl = (rttl << 8) | b;
        else rd_rem = ((rd_rem << 8) | b) & 32'hFFFF;
        lab_rem = (lab_rem - 1) & 32'h3F;
        if (lab_rem == 0) begin
          if (rd_rem == 0) close_record();
          else phase = dqp_pkg::PhRdata;
        end
      end
      dqp_pkg::PhRdata: begin
        rd_rem = (rd_rem - 1) & 32'hFFFF;
        if (rd_rem == 0) close_record();
      end
      default: ;
    endcase
    if (pos < 32'hFFFF) pos++;
    if (last) begin
      r = '0;
      if (idx < 11) v = dqp_pkg::VerdictDrop;
      else if (early != dqp_pkg::VerdictOk) v = early;
      else if (phase <= dqp_pkg::PhQfixed) v = dqp_pkg::VerdictFormErr;
      else v = dqp_pkg::VerdictOk;
      r.run_last = 1;
      r.verdict = v;
      r.query_id = hdr[0][15:0];
      r.query_flags = hdr[1][15:0];
      if (v == dqp_pkg::VerdictOk) begin
        r.question_type = q_type[15:0];
        r.question_class = q_class[15:0];
        r.question_end = q_end[15:0];
        if (phase == dqp_pkg::PhDone && !walk_bad && opt_hit) begin
          r.edns_present = 1;
          r.payload_size = opt_udp[15:0];
          r.dnssec_ok = opt_dnssec;
        end
      end
      r.name_valid_length = name_len > 255 ? 8'hFF : name_len[7:0];
      expected_results = {expected_results, r};
      clear_state();
    end
  endtask

  always @(posedge clk_i) begin
    dqp_pkg::out_t want;
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_i);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i !== want) begin
            fail_count_o++;
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) take_byte(in_data_i.data_byte, in_data_i.final_byte);
    end
    pending_o = expected_results.size();
  end
endmodule

// File: test/tb.sv
// Testbench top for the DNS query parser: builds DNS messages byte by byte,
// drives them with random idling and gives the verdict. Depends on dqp_pkg,
// dqp_checker and dns_query_parser.
`timescale 1ns / 1ps
module tb;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  dqp_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  dqp_pkg::out_t out_data;
  int unsigned fail_count, pending;
  int unsigned send_idle = 26, recv_idle = 67;
  int unsigned bytes_sent = 0;
  logic [7:0] msg[$];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  dns_query_parser u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  dqp_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk) out_ready <= $urandom_range(99) >= recv_idle;

  task automatic put8(input int unsigned v);
    msg = {msg, v[7:0]};
  endtask

  task automatic put16(input int unsigned w);
    put8(w >> 8);
    put8(w);
  endtask

  task automatic put_header(input int unsigned flags, qd, an, ns, ar);
    put16($urandom_range(65535));
    put16(flags);
    put16(qd);
    put16(an);
    put16(ns);
    put16(ar);
  endtask

  // Random label content: half bytes from 0x41 to 0x7A, half any byte.
  task automatic put_label(input int unsigned len);
    put8(len);
    repeat (len) put8($urandom_range(1) ? $urandom_range(255)
                                        : $urandom_range(8'h41, 8'h7A));
  endtask

  task automatic put_record(input logic is_opt);
    int unsigned rdlen;
    case ($urandom_range(2))
      0: put8(8'h00);
      1: begin
        put8(8'hC0);
        put8(8'h0C);
      end
      default: begin
        repeat ($urandom_range(1, 3)) put_label($urandom_range(1, 6));
        if ($urandom_range(1)) put8(8'h00);
        else begin
          put8($urandom_range(8'hC0, 8'hFF));
          put8($urandom_range(255));
        end
      end
    endcase
    put16(is_opt ? 41 : $urandom_range(65535));
    put16($urandom_range(1) ? $urandom_range(1023) : $urandom_range(65535));
    put16($urandom_range(65535));
    put16($urandom_range(65535));
    rdlen = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 5);
    put16(rdlen);
    repeat (rdlen) put8($urandom_range(255));
  endtask

  task automatic build_query();
    int unsigned an, ns, ar;
    an = $urandom_range(2);
    ns = $urandom_range(1);
    ar = $urandom_range(2);
    put_header($urandom_range(16'h7FFF), 1, an, ns, ar);
    repeat ($urandom_range(4)) put_label($urandom_range(1, 10));
    put8(8'h00);
    put16($urandom_range(65535));
    put16($urandom_range(65535));
    repeat (an + ns) put_record(0);
    repeat (ar) put_record($urandom_range(2) != 0);
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) put8($urandom_range(255));
  endtask

  // Sends the message buffer; the last byte carries the final mark.
  task automatic send_message();
    foreach (msg[i]) begin
      @(negedge clk);
      while ($urandom_range(99) < send_idle) begin
        in_valid <= 0;
        @(negedge clk);
      end
      in_valid <= 1;
      in_data.data_byte <= msg[i];
      in_data.final_byte <= (i == msg.size() - 1);
      do @(posedge clk); while (!in_ready);
      bytes_sent++;
    end
    @(negedge clk);
    in_valid <= 0;
    msg.delete();
  endtask

  initial begin
    int unsigned kind, cut, base;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Short message: a lone zero byte.
    put8(8'h00);
    send_message();
    // Response with a bad question count.
    put_header(16'h8000, 2, 0, 0, 0);
    send_message();
    // Question count of two.
    put_header(16'h0100, 2, 0, 0, 0);
    send_message();
    // Question label with a reserved top bit, then a compressed question.
    put_header(16'h0100, 1, 0, 0, 0);
    put8(8'h40);
    send_message();
    put_header(16'h0100, 1, 0, 0, 0);
    put8(8'hC0);
    put8(8'h0C);
    send_message();
    // Name of exactly 255 encoded bytes, then one whose next length byte overflows.
    put_header(16'h0000, 1, 0, 0, 0);
    repeat (3) put_label(63);
    put_label(62);
    put8(8'h00);
    put16(16'hFFFF);
    put16(16'hFFFF);
    send_message();
    put_header(16'h0000, 1, 0, 0, 0);
    repeat (3) put_label(63);
    put8(63);
    send_message();
    // Truncated after the type, before the class; root-only name with no records.
    put_header(16'h0100, 1, 0, 0, 0);
    put_label(3);
    put8(8'h00);
    put16(1);
    send_message();
    put_header(16'h7FFF, 1, 0, 0, 0);
    put8(8'h00);
    put16(1);
    put16(1);
    send_message();
    // Record walk failures: a label byte of 0x80, and too many labels.
    put_header(16'h0100, 1, 1, 0, 1);
    put8(8'h00);
    put16(1);
    put16(1);
    put8(8'h80);
    send_message();
    put_header(16'h0100, 1, 0, 0, 1);
    put8(8'h00);
    put16(1);
    put16(1);
    repeat (131) put_label(1);
    put8(8'h00);
    send_message();
    // Two OPT records, the last with a small size and the DO bit, then trailing bytes.
    put_header(16'h0100, 1, 0, 0, 2);
    put_label(5);
    put8(8'h00);
    put16(28);
    put16(1);
    put8(8'h00);
    put16(41); put16(4096); put16(0); put16(0); put16(0);
    put8(8'h00);
    put16(41); put16(100); put16(16'h0000); put16(16'h8000); put16(0);
    repeat (3) put8(8'hFF);
    send_message();

    base = bytes_sent;
    for (int phase_no = 1; phase_no < 3; phase_no++) begin
      send_idle = phase_no == 1 ? 67 : 0;
      recv_idle = phase_no == 1 ? 26 : 0;
      while (bytes_sent < base + 50 * phase_no) begin
        kind = $urandom_range(9);
        if (kind < 7) build_query();
        else if (kind == 7) repeat ($urandom_range(1, 30)) put8($urandom_range(255));
        else begin
          build_query();
          cut = $urandom_range(1, msg.size() - 1);
          if (kind == 8) while (msg.size() > cut) void'(msg.pop_back());
          else msg[cut] = 8'($urandom_range(255));
        end
        send_message();
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end
endmodule
